// ===== rtl/scc_pkg.sv =====
`timescale 1ns / 1ps
// Shared sizes, frame layout and control structs for the SCC unit.
// No dependencies; used by every module of the unit.
package scc_pkg;

	localparam int MAX_NODES = 64;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = NODE_W + 1;
	localparam int MAX_EDGES = 1024;
	localparam int EADDR_W   = $clog2(MAX_EDGES);
	localparam int ECNT_W    = EADDR_W + 1;
	localparam int EDGE_W    = 2 * NODE_W;
	localparam int TDATA_W   = 16;
	localparam int OUSER_W   = 2;

	// one depth-first frame: node and resume position
	typedef struct packed {
		logic [ECNT_W-1:0] pos;
		logic [NODE_W-1:0] node;
	} frame_t;

	// walker to output stage
	typedef struct packed {
		logic              emit;
		logic [NODE_W-1:0] node;
		logic [NODE_W-1:0] comp;
		logic              comp_end;
		logic              run_end;
		logic              busy;
	} walk_out_t;

endpackage

// ===== rtl/scc_loader.sv =====
`timescale 1ns / 1ps
// Edge loader: input transfers, edge memory, edge count and drop flag.
// Depends on scc_pkg.
module scc_loader (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [scc_pkg::TDATA_W-1:0]   s_tdata,
	input  logic                          s_tuser,
	input  logic                          s_tlast,
	input  logic [scc_pkg::CNT_W-1:0]     n_i,
	input  logic                          run_end_i,
	input  logic [scc_pkg::EADDR_W-1:0]   rd_addr,
	output logic [scc_pkg::EDGE_W-1:0]    rd_data,
	output logic [scc_pkg::ECNT_W-1:0]    edge_total,
	output logic                          drop,
	output logic                          start
);

	logic [scc_pkg::EDGE_W-1:0] mem [scc_pkg::MAX_EDGES];
	logic                       busy_q;
	logic                       acc;
	logic [scc_pkg::NODE_W-1:0] src, tgt;
	logic                       bad, wr;

	assign s_tready = !busy_q;
	assign acc      = s_tvalid && s_tready;
	assign src      = s_tdata[scc_pkg::NODE_W-1:0];
	assign tgt      = s_tdata[scc_pkg::EDGE_W-1:scc_pkg::NODE_W];
	assign bad      = ({1'b0, src} >= n_i) || ({1'b0, tgt} >= n_i)
		|| (edge_total == scc_pkg::ECNT_W'(scc_pkg::MAX_EDGES));
	assign wr       = acc && s_tuser && !bad;

	// edge memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr) begin
			mem[edge_total[scc_pkg::EADDR_W-1:0]] <= {src, tgt};
		end
		rd_data <= mem[rd_addr];
	end

	// count, drop flag and run control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total <= '0;
			drop       <= 1'b0;
			busy_q     <= 1'b0;
			start      <= 1'b0;
		end else begin
			start <= acc && s_tlast;
			if (wr) begin
				edge_total <= edge_total + 1'b1;
			end
			if (acc && s_tuser && bad) begin
				drop <= 1'b1;
			end
			if (acc && s_tlast) begin
				busy_q <= 1'b1;
			end
			if (run_end_i) begin
				busy_q     <= 1'b0;
				edge_total <= '0;
				drop       <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/scc_walker.sv =====
`timescale 1ns / 1ps
// Graph walker: forward pass, transpose build and transpose pass,
// with frame stack, finish order and in-neighbour row memories. Depends on scc_pkg.
module scc_walker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start_i,
	input  logic [scc_pkg::CNT_W-1:0]     n_i,
	input  logic [scc_pkg::ECNT_W-1:0]    edge_total_i,
	output logic [scc_pkg::EADDR_W-1:0]   er_addr,
	input  logic [scc_pkg::EDGE_W-1:0]    er_data,
	input  logic                          emit_ready_i,
	output scc_pkg::walk_out_t            wo
);

	typedef enum logic [3:0] {
		IDLE, P1_ROOT, P1_REQ, P1_CHK, P1_POP,
		B_REQ, B_RD, B_WR,
		P2_ROOT, P2_RD, P2_ROW, P2_SCAN, P2_POP, FLUSH
	} state_t;

	localparam int N = scc_pkg::MAX_NODES;
	localparam int NW = scc_pkg::NODE_W;

	state_t                       state_q;
	logic [N-1:0]                 visited_q, mvld_q, row_q;
	logic [scc_pkg::CNT_W-1:0]    d_q, root_q, fcnt_q, i_q;
	logic [NW-1:0]                top_node_q, comp_q, bs_q, bt_q;
	logic [scc_pkg::ECNT_W-1:0]   top_pos_q, idx_q;

	scc_pkg::frame_t              stk_mem [N];
	logic [NW-1:0]                fin_mem [N];
	logic [N-1:0]                 msk_mem [N];
	scc_pkg::frame_t              stk_rd, stk_wdata;
	logic [NW-1:0]                fin_rd, msk_raddr, stk_raddr, fin_raddr;
	logic [N-1:0]                 msk_rd, msk_wdata;
	logic                         stk_we, fin_we, msk_we;

	logic [scc_pkg::CNT_W-1:0]    d_m1, d_m2;
	logic [NW-1:0]                e_src, e_tgt, c, v;
	logic                         p1_end, p1_hit, p2_end, p2_hit, take;

	assign d_m1   = d_q - 1'b1;
	assign d_m2   = d_q - 2'd2;
	assign e_src  = er_data[scc_pkg::EDGE_W-1:NW];
	assign e_tgt  = er_data[NW-1:0];
	assign c      = top_pos_q[NW-1:0];
	assign v      = fin_rd;
	assign p1_end = top_pos_q >= edge_total_i;
	assign p1_hit = (e_src == top_node_q) && ({1'b0, e_tgt} < n_i) && !visited_q[e_tgt];
	assign p2_end = top_pos_q >= {{(scc_pkg::ECNT_W-scc_pkg::CNT_W){1'b0}}, n_i};
	assign p2_hit = row_q[c] && !visited_q[c];
	assign take   = ({1'b0, v} < n_i) && !visited_q[v];
	assign er_addr = (state_q == P1_REQ) ? top_pos_q[scc_pkg::EADDR_W-1:0]
		: idx_q[scc_pkg::EADDR_W-1:0];

	// memory controls and walker outputs
	always_comb begin
		stk_we     = 1'b0;
		stk_wdata  = '{pos: top_pos_q, node: top_node_q};
		stk_raddr  = d_m2[NW-1:0];
		fin_we     = 1'b0;
		fin_raddr  = i_q[NW-1:0] - 1'b1;
		msk_we     = 1'b0;
		msk_raddr  = '0;
		msk_wdata  = (mvld_q[bt_q] ? msk_rd : '0) | ({{(N-1){1'b0}}, 1'b1} << bs_q);
		wo         = '0;
		wo.busy    = (state_q != IDLE);
		wo.comp    = comp_q;
		case (state_q)
			P1_REQ: fin_we = p1_end;
			P1_CHK: stk_we = p1_hit;
			B_RD:   msk_raddr = e_tgt;
			B_WR:   msk_we = 1'b1;
			P2_RD: begin
				msk_raddr = v;
				wo.node   = v;
				wo.emit   = take && emit_ready_i;
			end
			P2_SCAN: begin
				msk_raddr = c;
				wo.node   = c;
				if (p2_end) begin
					wo.comp_end = (d_q == scc_pkg::CNT_W'(1));
				end else if (p2_hit && emit_ready_i) begin
					wo.emit       = 1'b1;
					stk_we        = 1'b1;
					stk_wdata.pos = top_pos_q + 1'b1;
				end
			end
			P2_POP: msk_raddr = stk_rd.node;
			FLUSH:  wo.run_end = emit_ready_i;
			default: ;
		endcase
	end

	// memories with registered reads
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[d_m1[NW-1:0]] <= stk_wdata;
		end
		stk_rd <= stk_mem[stk_raddr];
		if (fin_we) begin
			fin_mem[fcnt_q[NW-1:0]] <= top_node_q;
		end
		fin_rd <= fin_mem[fin_raddr];
		if (msk_we) begin
			msk_mem[bt_q] <= msk_wdata;
		end
		msk_rd <= msk_mem[msk_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			visited_q  <= '0;
			mvld_q     <= '0;
			row_q      <= '0;
			d_q        <= '0;
			root_q     <= '0;
			fcnt_q     <= '0;
			i_q        <= '0;
			top_node_q <= '0;
			top_pos_q  <= '0;
			idx_q      <= '0;
			comp_q     <= '0;
			bs_q       <= '0;
			bt_q       <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (start_i) begin
						visited_q <= '0;
						root_q    <= '0;
						fcnt_q    <= '0;
						state_q   <= P1_ROOT;
					end
				end
				P1_ROOT: begin
					if (root_q >= n_i) begin
						idx_q     <= '0;
						mvld_q    <= '0;
						visited_q <= '0;
						state_q   <= B_REQ;
					end else if (visited_q[root_q[NW-1:0]]) begin
						root_q <= root_q + 1'b1;
					end else begin
						visited_q[root_q[NW-1:0]] <= 1'b1;
						top_node_q <= root_q[NW-1:0];
						top_pos_q  <= '0;
						d_q        <= scc_pkg::CNT_W'(1);
						state_q    <= P1_REQ;
					end
				end
				P1_REQ: begin
					if (p1_end) begin
						fcnt_q <= fcnt_q + 1'b1;
						d_q    <= d_m1;
						if (d_q == scc_pkg::CNT_W'(1)) begin
							root_q  <= root_q + 1'b1;
							state_q <= P1_ROOT;
						end else begin
							state_q <= P1_POP;
						end
					end else begin
						top_pos_q <= top_pos_q + 1'b1;
						state_q   <= P1_CHK;
					end
				end
				P1_CHK: begin
					if (p1_hit) begin
						visited_q[e_tgt] <= 1'b1;
						top_node_q <= e_tgt;
						top_pos_q  <= '0;
						d_q        <= d_q + 1'b1;
					end
					state_q <= P1_REQ;
				end
				P1_POP: begin
					top_node_q <= stk_rd.node;
					top_pos_q  <= stk_rd.pos;
					state_q    <= P1_REQ;
				end
				B_REQ: begin
					if (idx_q >= edge_total_i) begin
						i_q     <= fcnt_q;
						comp_q  <= '0;
						state_q <= P2_ROOT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= B_RD;
					end
				end
				B_RD: begin
					bs_q <= e_src;
					bt_q <= e_tgt;
					if (({1'b0, e_src} < n_i) && ({1'b0, e_tgt} < n_i)) begin
						state_q <= B_WR;
					end else begin
						state_q <= B_REQ;
					end
				end
				B_WR: begin
					mvld_q[bt_q] <= 1'b1;
					state_q      <= B_REQ;
				end
				P2_ROOT: begin
					state_q <= (i_q == '0) ? FLUSH : P2_RD;
				end
				P2_RD: begin
					if (!take) begin
						i_q     <= i_q - 1'b1;
						state_q <= P2_ROOT;
					end else if (emit_ready_i) begin
						i_q          <= i_q - 1'b1;
						visited_q[v] <= 1'b1;
						top_node_q   <= v;
						top_pos_q    <= '0;
						d_q          <= scc_pkg::CNT_W'(1);
						state_q      <= P2_ROW;
					end
				end
				P2_ROW: begin
					row_q   <= mvld_q[top_node_q] ? msk_rd : '0;
					state_q <= P2_SCAN;
				end
				P2_SCAN: begin
					if (p2_end) begin
						d_q <= d_m1;
						if (d_q == scc_pkg::CNT_W'(1)) begin
							comp_q  <= comp_q + 1'b1;
							state_q <= P2_ROOT;
						end else begin
							state_q <= P2_POP;
						end
					end else if (p2_hit) begin
						if (emit_ready_i) begin
							visited_q[c] <= 1'b1;
							top_node_q   <= c;
							top_pos_q    <= '0;
							d_q          <= d_q + 1'b1;
							state_q      <= P2_ROW;
						end
					end else begin
						top_pos_q <= top_pos_q + 1'b1;
					end
				end
				P2_POP: begin
					top_node_q <= stk_rd.node;
					top_pos_q  <= stk_rd.pos;
					state_q    <= P2_ROW;
				end
				FLUSH: begin
					if (emit_ready_i) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/scc_out_stage.sv =====
`timescale 1ns / 1ps
// Output stage: holds one result back until its end marks are known,
// then presents it in the output register. Depends on scc_pkg.
module scc_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scc_pkg::walk_out_t            wo,
	input  logic                          drop_i,
	output logic                          emit_ready,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [scc_pkg::TDATA_W-1:0]   m_tdata,
	output logic                          m_tlast,
	output logic [scc_pkg::OUSER_W-1:0]   m_tuser
);

	localparam int NW = scc_pkg::NODE_W;

	logic          pend_v_q, pend_end_q, pend_drop_q, out_free;
	logic [NW-1:0] pend_node_q, pend_comp_q;
	logic          fwd;

	assign out_free   = !m_tvalid || m_tready;
	assign emit_ready = out_free || !pend_v_q;
	assign fwd        = pend_v_q && (wo.emit || wo.run_end);

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (fwd) begin
				m_tvalid <= 1'b1;
			end
			if (wo.emit) begin
				pend_v_q <= 1'b1;
			end else if (wo.run_end) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// held result and output payload
	always_ff @(posedge clk) begin
		if (fwd) begin
			m_tdata <= {{(scc_pkg::TDATA_W-2*NW){1'b0}}, pend_comp_q, pend_node_q};
			m_tuser <= {pend_drop_q, pend_end_q};
			m_tlast <= wo.run_end;
		end
		if (wo.emit) begin
			pend_node_q <= wo.node;
			pend_comp_q <= wo.comp;
			pend_drop_q <= drop_i;
			pend_end_q  <= 1'b0;
		end else if (wo.comp_end) begin
			pend_end_q <= 1'b1;
		end
	end

endmodule

// ===== rtl/strongly_connected_components_unit.sv =====
`timescale 1ns / 1ps
// Strongly connected components by Kosaraju's method; top level.
// Edges load at one transfer per cycle while no run is in progress. After the last
// item: the forward pass scans the edge list per node visit (edge memory read port),
// the transpose build reads each edge once, the transpose pass scans the candidates
// per node visit and pops stack frames. Reset: node_count 64, edge memory empty.
module strongly_connected_components_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [scc_pkg::CNT_W-1:0]       cfg_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [scc_pkg::TDATA_W-1:0]     s_axis_tdata,  // source_node, target_node
	input  logic                            s_axis_tuser,  // has_edge
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [scc_pkg::TDATA_W-1:0]     m_axis_tdata,  // node_id, component_index
	output logic [scc_pkg::OUSER_W-1:0]     m_axis_tuser,  // component_end, edges_dropped
	output logic                            m_axis_tlast
);

	logic [scc_pkg::CNT_W-1:0]   node_count_q, n_eff;
	logic [scc_pkg::EADDR_W-1:0] er_addr;
	logic [scc_pkg::EDGE_W-1:0]  er_data;
	logic [scc_pkg::ECNT_W-1:0]  edge_total;
	logic                        drop, start, emit_ready;
	scc_pkg::walk_out_t          wo;

	// node count register, saturated for use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= scc_pkg::CNT_W'(scc_pkg::MAX_NODES);
		end else if (cfg_wen) begin
			node_count_q <= cfg_wdata;
		end
	end
	assign n_eff = (node_count_q > scc_pkg::CNT_W'(scc_pkg::MAX_NODES))
		? scc_pkg::CNT_W'(scc_pkg::MAX_NODES) : node_count_q;

	scc_loader u_loader (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.s_tuser    (s_axis_tuser),
		.s_tlast    (s_axis_tlast),
		.n_i        (n_eff),
		.run_end_i  (wo.run_end),
		.rd_addr    (er_addr),
		.rd_data    (er_data),
		.edge_total (edge_total),
		.drop       (drop),
		.start      (start)
	);

	scc_walker u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_i      (start),
		.n_i          (n_eff),
		.edge_total_i (edge_total),
		.er_addr      (er_addr),
		.er_data      (er_data),
		.emit_ready_i (emit_ready),
		.wo           (wo)
	);

	scc_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.wo         (wo),
		.drop_i     (drop),
		.emit_ready (emit_ready),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tlast    (m_axis_tlast),
		.m_tuser    (m_axis_tuser)
	);

	// no input transfer while the walker runs
	a_no_load_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		wo.busy |-> !s_axis_tready) else $error("input ready during walk");

	// results only leave the walker when the output stage has room
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		wo.emit |-> emit_ready) else $error("result emitted without room");

	// a run ends with the walker going idle next cycle
	a_run_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wo.run_end |=> !wo.busy) else $error("walker still busy after run end");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for strongly_connected_components_unit.
// Loads random and directed graphs over the input stream, predicts the component
// listing in the testbench and checks every output transfer. Depends on scc_pkg.
module testbench;

	typedef struct {
		logic [scc_pkg::NODE_W-1:0] src;
		logic [scc_pkg::NODE_W-1:0] dst;
		logic                       has_edge;
		logic                       last_edge;
	} edge_item_t;

	typedef struct {
		logic [scc_pkg::NODE_W-1:0] node;
		logic [scc_pkg::NODE_W-1:0] comp;
		logic                       comp_end;
		logic                       run_end;
		logic                       dropped;
	} scc_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [scc_pkg::CNT_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [scc_pkg::TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [scc_pkg::TDATA_W-1:0] m_axis_tdata;
	logic [scc_pkg::OUSER_W-1:0] m_axis_tuser;
	logic m_axis_tlast;

	strongly_connected_components_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
	);

	always #10 clk = ~clk;

	// pending edge items, expected component listing, failure count
	edge_item_t edge_queue[$];
	scc_entry_t scc_expected[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;

	// predictor state
	logic [scc_pkg::CNT_W-1:0] node_count_sh = 7'd64;
	logic [scc_pkg::NODE_W-1:0] mem_src[scc_pkg::MAX_EDGES];
	logic [scc_pkg::NODE_W-1:0] mem_dst[scc_pkg::MAX_EDGES];
	int mem_total = 0;
	bit drop_seen = 1'b0;

	// Kosaraju on the shadow edge memory; appends the listing to scc_expected
	task automatic list_components(int n);
		bit vis[scc_pkg::MAX_NODES];
		int fin[scc_pkg::MAX_NODES];
		int stn[scc_pkg::MAX_NODES];
		int stp[scc_pkg::MAX_NODES];
		logic [scc_pkg::MAX_NODES-1:0] in_set[scc_pkg::MAX_NODES];
		scc_entry_t res[scc_pkg::MAX_NODES];
		int fcnt, sp, top, s, k, t, c, cnt, comp, v;
		bit found;
		fcnt = 0;
		cnt = 0;
		comp = 0;
		for (int i = 0; i < scc_pkg::MAX_NODES; i++) vis[i] = 0;
		// forward pass: finish order
		for (int r = 0; r < n; r++) begin
			if (vis[r]) continue;
			vis[r] = 1;
			stn[0] = r;
			stp[0] = 0;
			sp = 1;
			while (sp > 0) begin
				top = sp - 1;
				s = stn[top];
				k = stp[top];
				found = 0;
				t = 0;
				while (k < mem_total) begin
					t = mem_dst[k];
					k++;
					if (mem_src[k-1] == s && t < n && !vis[t]) begin
						found = 1;
						break;
					end
				end
				stp[top] = k;
				if (found && sp < scc_pkg::MAX_NODES) begin
					vis[t] = 1;
					stn[sp] = t;
					stp[sp] = 0;
					sp++;
				end else begin
					sp--;
					if (fcnt < scc_pkg::MAX_NODES) begin
						fin[fcnt] = s;
						fcnt++;
					end
				end
			end
		end
		// transpose as in-neighbour sets
		for (int i = 0; i < scc_pkg::MAX_NODES; i++) begin
			in_set[i] = '0;
			vis[i] = 0;
		end
		for (int i = 0; i < mem_total; i++)
			if (mem_src[i] < n && mem_dst[i] < n) in_set[mem_dst[i]][mem_src[i]] = 1'b1;
		// transpose pass in reverse finish order
		for (int i = fcnt; i > 0; i--) begin
			v = fin[i-1];
			if (v >= n || vis[v]) continue;
			vis[v] = 1;
			res[cnt] = '{scc_pkg::NODE_W'(v), scc_pkg::NODE_W'(comp), 1'b0, 1'b0, drop_seen};
			cnt++;
			stn[0] = v;
			stp[0] = 0;
			sp = 1;
			while (sp > 0) begin
				top = sp - 1;
				s = stn[top];
				c = stp[top];
				found = 0;
				while (c < n) begin
					if (in_set[s][c] && !vis[c]) begin
						found = 1;
						break;
					end
					c++;
				end
				if (found && sp < scc_pkg::MAX_NODES && cnt < scc_pkg::MAX_NODES) begin
					stp[top] = c + 1;
					vis[c] = 1;
					res[cnt] = '{scc_pkg::NODE_W'(c), scc_pkg::NODE_W'(comp), 1'b0, 1'b0,
						drop_seen};
					cnt++;
					stn[sp] = c;
					stp[sp] = 0;
					sp++;
				end else begin
					stp[top] = n;
					sp--;
				end
			end
			res[cnt-1].comp_end = 1'b1;
			comp++;
		end
		if (cnt > 0) res[cnt-1].run_end = 1'b1;
		for (int i = 0; i < cnt; i++) scc_expected.insert(scc_expected.size(), res[i]);
	endtask

	// one accepted input item against the shadow state
	task automatic apply_edge_item(edge_item_t it);
		int n;
		n = (node_count_sh > scc_pkg::MAX_NODES) ? scc_pkg::MAX_NODES : node_count_sh;
		if (it.has_edge) begin
			if (it.src >= n || it.dst >= n || mem_total >= scc_pkg::MAX_EDGES) drop_seen = 1'b1;
			else begin
				mem_src[mem_total] = it.src;
				mem_dst[mem_total] = it.dst;
				mem_total++;
			end
		end
		if (it.last_edge) begin
			list_components(n);
			mem_total = 0;
			drop_seen = 1'b0;
		end
	endtask

	// shadow of the node count register
	always @(posedge clk) begin
		if (cfg_wen) node_count_sh <= cfg_wdata;
	end

	// sender: predicts on each accepted transfer, then offers the next item
	always @(posedge clk or negedge arst_n) begin
		edge_item_t it;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				it.src = s_axis_tdata[5:0];
				it.dst = s_axis_tdata[11:6];
				it.has_edge = s_axis_tuser;
				it.last_edge = s_axis_tlast;
				apply_edge_item(it);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (edge_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					it = edge_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {4'b0, it.dst, it.src};
					s_axis_tuser <= it.has_edge;
					s_axis_tlast <= it.last_edge;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with one long hold-off on request
	int hold_cnt = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			m_axis_tready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == 3000) hold_done <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// output checker
	always @(posedge clk) begin
		scc_entry_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (scc_expected.size() == 0) begin
				$error("unexpected output transfer node_id=%0d", m_axis_tdata[5:0]);
				errors++;
			end else begin
				e = scc_expected.pop_front();
				if (m_axis_tdata[5:0] !== e.node) begin
					$error("node_id expected %0d got %0d", e.node, m_axis_tdata[5:0]);
					errors++;
				end
				if (m_axis_tdata[11:6] !== e.comp) begin
					$error("component_index expected %0d got %0d", e.comp, m_axis_tdata[11:6]);
					errors++;
				end
				if (m_axis_tuser[0] !== e.comp_end) begin
					$error("component_end expected %0d got %0d", e.comp_end, m_axis_tuser[0]);
					errors++;
				end
				if (m_axis_tlast !== e.run_end) begin
					$error("final_result expected %0d got %0d", e.run_end, m_axis_tlast);
					errors++;
				end
				if (m_axis_tuser[1] !== e.dropped) begin
					$error("edges_dropped expected %0d got %0d", e.dropped, m_axis_tuser[1]);
					errors++;
				end
			end
		end
	end

	task automatic push_edge(int s, int d, bit he, bit le);
		edge_item_t it;
		it.src = scc_pkg::NODE_W'(s);
		it.dst = scc_pkg::NODE_W'(d);
		it.has_edge = he;
		it.last_edge = le;
		edge_queue.insert(edge_queue.size(), it);
	endtask

	// everything sent and answered, then let the walk settle
	task automatic drain();
		while (edge_queue.size() > 0 || s_axis_tvalid || scc_expected.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_node_count(int v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= scc_pkg::CNT_W'(v);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// random graph: mostly in-range edges, some out of range and some empty items
	task automatic random_graph(int n);
		int ne, lim;
		ne = $urandom_range(1, 24);
		lim = (n < 1) ? 1 : ((n > 64) ? 64 : n);
		for (int i = 0; i < ne; i++) begin
			case ($urandom_range(9))
				0: push_edge($urandom_range(63), $urandom_range(63), 1'b1, 1'b0);
				1: push_edge($urandom_range(63), $urandom_range(63), 1'b0, 1'b0);
				default: push_edge($urandom_range(lim - 1), $urandom_range(lim - 1), 1'b1, 1'b0);
			endcase
		end
		push_edge($urandom_range(lim - 1), $urandom_range(lim - 1), 1'($urandom_range(1)),
			1'b1);
	endtask

	function automatic int pick_count();
		case ($urandom_range(9))
			0: return 1;
			1: return 64;
			2: return 127;
			3: return 0;
			4: return $urandom_range(65, 126);
			default: return $urandom_range(2, 20);
		endcase
	endfunction

	int cnt_now;
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset count, extremes, self loop, cycle, empty item, edge with last
		push_edge(0, 63, 1'b1, 1'b0);
		push_edge(63, 0, 1'b1, 1'b0);
		push_edge(5, 5, 1'b1, 1'b0);
		push_edge(42, 21, 1'b0, 1'b0);
		push_edge(21, 42, 1'b1, 1'b1);
		drain();
		set_node_count(4);
		push_edge(5, 1, 1'b1, 1'b0);
		push_edge(0, 1, 1'b1, 1'b0);
		push_edge(1, 2, 1'b1, 1'b0);
		push_edge(2, 0, 1'b1, 1'b0);
		push_edge(3, 3, 1'b1, 1'b1);
		drain();
		push_edge(1, 3, 1'b1, 1'b0);
		push_edge(0, 0, 1'b0, 1'b1);
		drain();
		// count lowered after loading
		set_node_count(64);
		push_edge(0, 10, 1'b1, 1'b0);
		push_edge(10, 0, 1'b1, 1'b0);
		push_edge(1, 0, 1'b1, 1'b0);
		drain();
		set_node_count(2);
		push_edge(0, 0, 1'b0, 1'b1);
		drain();
		// zero nodes: all dropped, no results
		set_node_count(0);
		push_edge(0, 0, 1'b1, 1'b0);
		push_edge(0, 0, 1'b1, 1'b1);
		drain();

		// random phases: no gaps, sender idles, back pressure, then light idles and back pressure
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? 55 : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? 55 : 0;
			if (ph == 3) begin
				send_idle_pct = 6;
				recv_stall_pct = 6;
			end
			for (int g = 0; g < 5; g++) begin
				cnt_now = pick_count();
				set_node_count(cnt_now);
				random_graph(cnt_now);
				drain();
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 20;
		set_node_count(64);
		hold_req = 1'b1;
		for (int g = 0; g < 4; g++) random_graph(64);
		drain();

		if (errors == 0)
			$display("[strongly_connected_components_unit] OK");
		else
			$display("[strongly_connected_components_unit] ERROR");
		$finish;
	end

	initial begin
		#40ms;
		$display("[strongly_connected_components_unit] ERROR");
		$finish;
	end

endmodule
